// ===== hw/rtl/brle_pkg.sv =====
// Shared types and constants for the byte run-length decoder.
package brle_pkg;

  // Fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TotalW = 24;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CntW   = 2;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // Header byte layout: bit 7 flags a literal block, low 7 bits hold count-1
  localparam int unsigned LitFlagBit = 7;
  localparam int unsigned HdrLenW    = 7;

  // Input actions
  localparam logic ActData   = 1'b0;
  localparam logic ActFinish = 1'b1;

  // Register word index of expected_length
  localparam logic RegExpLen = 1'b0;

  // Beat byte counts
  localparam logic [CntW-1:0] CntNone = 2'd0;
  localparam logic [CntW-1:0] CntOne  = 2'd1;
  localparam logic [CntW-1:0] CntTwo  = 2'd2;

  typedef enum logic [StatW-1:0] {
    ST_DATA     = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_OK       = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_SHORT    = 3'd4
  } status_e;

  // Datapath operations requested by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_HEADER,
    OP_LITERAL,
    OP_RUNVAL,
    OP_RUN_BEAT,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic pending;  // literal block or run value still open at finish
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
    logic overflow;  // sticky overflow flag
    logic hdr_fits;  // header on the input fits under expected_length
    logic rem_le1;   // remaining count is at most one
    logic rem_le2;   // remaining count is at most two
  } dp_status_t;

  typedef struct packed {
    logic [ByteW-1:0]  byte_first;
    logic [ByteW-1:0]  byte_second;
    logic [CntW-1:0]   byte_count;
    logic              last_of_run;
    logic [StatW-1:0]  status;
    logic [TotalW-1:0] total_out;
  } out_word_t;

endpackage

// ===== hw/rtl/brle_if.sv =====
// Valid/ready stream interfaces for the input and output channels.
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink (input valid, input action, input in_byte, output ready);
endinterface

interface brle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte_first;
  logic [7:0]  out_byte_second;
  logic [1:0]  byte_count;
  logic        last_of_run;
  logic [2:0]  status;
  logic [23:0] total_out;

  modport source (output valid, output out_byte_first, output out_byte_second,
                  output byte_count, output last_of_run, output status,
                  output total_out, input ready);
  modport sink (input valid, input out_byte_first, input out_byte_second,
                input byte_count, input last_of_run, input status,
                input total_out, output ready);
endinterface

// ===== hw/rtl/brle_ctrl.sv =====
// Decoder controller: stream phase state machine and operation select.
module brle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_action_i,
  input  logic                   in_lit_flag_i,
  input  brle_pkg::dp_status_t   status_i,
  output logic                   in_ready_o,
  output brle_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_HEADER,
    S_LITERAL,
    S_RUNVAL,
    S_RUN
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  // Input is held off while run beats drain or the output word is blocked
  assign in_ready_o = status_i.out_free && (state_q != S_RUN);
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = brle_pkg::OP_NONE;
    cmd_o.pending = (state_q == S_LITERAL) || (state_q == S_RUNVAL);
    unique case (state_q)
      S_RUN: begin
        if (status_i.out_free) begin
          cmd_o.op = brle_pkg::OP_RUN_BEAT;
          if (status_i.rem_le2) begin
            state_d = S_HEADER;
          end
        end
      end
      default: begin
        if (fire) begin
          if (in_action_i == brle_pkg::ActFinish) begin
            cmd_o.op = brle_pkg::OP_FINISH;
            state_d  = S_HEADER;
          end else if (!status_i.overflow) begin
            unique case (state_q)
              S_LITERAL: begin
                cmd_o.op = brle_pkg::OP_LITERAL;
                if (status_i.rem_le1) begin
                  state_d = S_HEADER;
                end
              end
              S_RUNVAL: begin
                cmd_o.op = brle_pkg::OP_RUNVAL;
                state_d  = status_i.rem_le2 ? S_HEADER : S_RUN;
              end
              default: begin
                cmd_o.op = brle_pkg::OP_HEADER;
                if (status_i.hdr_fits) begin
                  state_d = in_lit_flag_i ? S_LITERAL : S_RUNVAL;
                end
              end
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/brle_dp.sv =====
// Decoder datapath: length register, counters, run byte and output word register.
module brle_dp #(
  parameter int unsigned LenW = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // register write/read
  input  logic                                  cfg_we_i,
  input  logic [LenW-1:0]                       cfg_wdata_i,
  output logic [LenW-1:0]                       expected_o,
  // input word payload
  input  logic [brle_pkg::ByteW-1:0]            in_byte_i,
  // controller link
  input  brle_pkg::ctrl_cmd_t                   cmd_i,
  output brle_pkg::dp_status_t                  status_o,
  // output word
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output brle_pkg::out_word_t                   out_word_o
);

  localparam int unsigned SumW = LenW + 1;
  localparam int unsigned RemW = brle_pkg::HdrLenW + 1;

  logic [LenW-1:0]            expected_q;
  logic [LenW-1:0]            total_q, total_d;
  logic [RemW-1:0]            remaining_q, remaining_d;
  logic                       overflow_q, overflow_d;
  logic [brle_pkg::ByteW-1:0] run_byte_q, run_byte_d;
  logic                       out_valid_q, out_valid_d;
  brle_pkg::out_word_t        word_q, word_d;

  logic [RemW-1:0]            hdr_count;
  logic [SumW-1:0]            hdr_sum;
  logic                       hdr_fits;
  logic                       beat_two;
  logic [RemW-1:0]            beat_left;
  logic [brle_pkg::ByteW-1:0] beat_byte;
  brle_pkg::status_e          fin_status;

  // Header count and overflow check
  assign hdr_count = RemW'(in_byte_i[brle_pkg::HdrLenW-1:0]) + RemW'(1);
  assign hdr_sum   = SumW'(total_q) + SumW'(hdr_count);
  assign hdr_fits  = hdr_sum <= SumW'(expected_q);

  // Run beat: two bytes while at least two remain
  assign beat_two  = remaining_q >= RemW'(2);
  assign beat_left = remaining_q - (beat_two ? RemW'(2) : RemW'(1));
  assign beat_byte = (cmd_i.op == brle_pkg::OP_RUNVAL) ? in_byte_i : run_byte_q;

  // Finish status priority
  always_comb begin
    if (overflow_q) begin
      fin_status = brle_pkg::ST_OVERFLOW;
    end else if (cmd_i.pending) begin
      fin_status = brle_pkg::ST_TRUNC;
    end else if (total_q != expected_q) begin
      fin_status = brle_pkg::ST_SHORT;
    end else begin
      fin_status = brle_pkg::ST_OK;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.overflow = overflow_q;
  assign status_o.hdr_fits = hdr_fits;
  assign status_o.rem_le1  = remaining_q <= RemW'(1);
  assign status_o.rem_le2  = remaining_q <= RemW'(2);

  // Operation execute
  always_comb begin
    total_d     = total_q;
    remaining_d = remaining_q;
    overflow_d  = overflow_q;
    run_byte_d  = run_byte_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      brle_pkg::OP_HEADER: begin
        if (hdr_fits) begin
          total_d     = hdr_sum[LenW-1:0];
          remaining_d = hdr_count;
        end else begin
          overflow_d  = 1'b1;
          remaining_d = '0;
          out_valid_d = 1'b1;
          word_d.byte_first  = '0;
          word_d.byte_second = '0;
          word_d.byte_count  = brle_pkg::CntNone;
          word_d.last_of_run = 1'b1;
          word_d.status      = brle_pkg::ST_OVERFLOW;
          word_d.total_out   = brle_pkg::TotalW'(total_q);
        end
      end
      brle_pkg::OP_LITERAL: begin
        if (remaining_q != '0) begin
          remaining_d = remaining_q - RemW'(1);
        end
        out_valid_d = 1'b1;
        word_d.byte_first  = in_byte_i;
        word_d.byte_second = '0;
        word_d.byte_count  = brle_pkg::CntOne;
        word_d.last_of_run = 1'b1;
        word_d.status      = brle_pkg::ST_DATA;
        word_d.total_out   = brle_pkg::TotalW'(total_q);
      end
      brle_pkg::OP_RUNVAL, brle_pkg::OP_RUN_BEAT: begin
        run_byte_d  = beat_byte;
        remaining_d = beat_left;
        out_valid_d = 1'b1;
        word_d.byte_first  = beat_byte;
        word_d.byte_second = beat_two ? beat_byte : '0;
        word_d.byte_count  = beat_two ? brle_pkg::CntTwo : brle_pkg::CntOne;
        word_d.last_of_run = (beat_left == '0);
        word_d.status      = brle_pkg::ST_DATA;
        word_d.total_out   = brle_pkg::TotalW'(total_q);
      end
      brle_pkg::OP_FINISH: begin
        total_d     = '0;
        remaining_d = '0;
        overflow_d  = 1'b0;
        out_valid_d = 1'b1;
        word_d.byte_first  = '0;
        word_d.byte_second = '0;
        word_d.byte_count  = brle_pkg::CntNone;
        word_d.last_of_run = 1'b1;
        word_d.status      = fin_status;
        word_d.total_out   = brle_pkg::TotalW'(total_q);
      end
      default: begin
      end
    endcase
  end

  // Control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q  <= '1;
      total_q     <= '0;
      remaining_q <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expected_q <= cfg_wdata_i;
      end
      total_q     <= total_d;
      remaining_q <= remaining_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_byte_q <= run_byte_d;
    word_q     <= word_d;
  end

  assign expected_o  = expected_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== hw/rtl/byte_rle_decoder.sv =====
// Top level of the byte run-length decoder.
//
// in_i carries one word per packed stream byte: action selects data or finish,
// in_byte holds the packed byte. out_o carries decoded beats of up to two bytes
// with byte_count, last_of_run, status and the running total_out.
// expected_length is written over the APB port at byte address 0 while idle.
//
// A header byte gives no beat, or a status beat on overflow; the next byte can
// be taken in the following cycle. A literal byte gives one beat in the next
// cycle. Unless the receiver stalls, literals stream at one byte per cycle and
// a run value byte gives ceil(n/2) beats at one per cycle; it holds in_i.ready
// low until the last beat is loaded; the single output word register sets this
// rate. A finish word gives one status beat and clears the stream state.
//
// Reset clears the stream state and sets expected_length to all ones. When the
// receiver stalls, the output word is held and in_i.ready drops until it is taken.
module byte_rle_decoder #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  brle_in_if.sink                       in_i,
  brle_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brle_pkg::AddrW-1:0]    paddr,
  input  logic [brle_pkg::DataW-1:0]    pwdata,
  output logic [brle_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned LenW =
    (LENGTH_BITS < brle_pkg::TotalW) ? LENGTH_BITS : brle_pkg::TotalW;

  brle_pkg::ctrl_cmd_t  cmd;
  brle_pkg::dp_status_t dp_status;
  brle_pkg::out_word_t  out_word;
  logic                 cfg_we;
  logic                 reg_hit;
  logic [LenW-1:0]      expected;

  // Register decode on the word address
  assign reg_hit = paddr[brle_pkg::AddrW-1] == brle_pkg::RegExpLen;
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? brle_pkg::DataW'(expected) : '0;

  brle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_action_i   (in_i.action),
    .in_lit_flag_i (in_i.in_byte[brle_pkg::LitFlagBit]),
    .status_i      (dp_status),
    .in_ready_o    (in_i.ready),
    .cmd_o         (cmd)
  );

  brle_dp #(
    .LenW (LenW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[LenW-1:0]),
    .expected_o  (expected),
    .in_byte_i   (in_i.in_byte),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  assign out_o.out_byte_first  = out_word.byte_first;
  assign out_o.out_byte_second = out_word.byte_second;
  assign out_o.byte_count      = out_word.byte_count;
  assign out_o.last_of_run     = out_word.last_of_run;
  assign out_o.status          = out_word.status;
  assign out_o.total_out       = out_word.total_out;

endmodule

// ===== hw/rtl/brle_checker.sv =====
// Port-level checks for the byte run-length decoder, bound to the top level.
module brle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  byte_count_i,
  input logic        last_of_run_i,
  input logic [2:0]  status_i
);

  // A stalled output word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // Status words carry no bytes and close the input's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != brle_pkg::ST_DATA) |->
      (byte_count_i == brle_pkg::CntNone) && last_of_run_i)
    else $error("status word with data or not last");

  // Data words carry one or two bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == brle_pkg::ST_DATA) |->
      (byte_count_i == brle_pkg::CntOne) || (byte_count_i == brle_pkg::CntTwo))
    else $error("data word with bad byte count");

  // No new input while the output word is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output blocked");

endmodule

bind byte_rle_decoder brle_checker u_brle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .byte_count_i  (out_o.byte_count),
  .last_of_run_i (out_o.last_of_run),
  .status_i      (out_o.status)
);
